// File: src/skbs_pkg.sv
// shared types, codes and widths for the sorted key binary search table
// depends on nothing; used by the top level
`default_nettype none

package skbs_pkg;

  localparam int KEY_W = 64;
  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int TABLE_DEPTH_DEF = 1024;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_RSVD   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_ORDER     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic                    flag;
  } entry_t;

endpackage

`default_nettype wire

// File: src/skbs_ram.sv
// generic simple dual port ram, one write port and one registered read port
// depends on nothing
`default_nettype none

module skbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: src/sorted_key_binary_search_table.sv
// top level of the sorted key binary search table
// depends on skbs_pkg and skbs_ram
`default_nettype none

// A table of up to TABLE_DEPTH entries kept in ascending key order in one
// synchronous ram. A transaction is taken when start is high and busy is low;
// its single result appears on the result ports for one cycle with done high,
// and the receiver cannot stall it. Clear, load and reserved requests give
// their result in the cycle after acceptance and leave busy low, so one may
// follow every cycle. A lookup probes the table by issuing an address, then
// comparing on the registered read data, and repeats these steps until the
// key is found or the search range is empty, with busy high throughout. A
// lookup in an empty table answers in the next cycle.

module sorted_key_binary_search_table #(
  parameter int TABLE_DEPTH = skbs_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [1:0]                           req_type,
  input  wire logic signed [skbs_pkg::KEY_W-1:0]    key,
  input  wire logic signed [skbs_pkg::LAT_W-1:0]    lat_in,
  input  wire logic signed [skbs_pkg::LON_W-1:0]    lon_in,
  input  wire logic                                 entrance_in,
  output logic                                      done,
  output logic [1:0]                                status,
  output logic signed [skbs_pkg::LAT_W-1:0]         lat_out,
  output logic signed [skbs_pkg::LON_W-1:0]         lon_out,
  output logic                                      entrance_out
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(skbs_pkg::entry_t);

  skbs_pkg::state_t state, state_next;

  logic [CW-1:0]                       count, count_next;
  logic signed [skbs_pkg::KEY_W-1:0]   last_key, last_key_next;
  logic signed [skbs_pkg::KEY_W-1:0]   target, target_next;
  logic [CW-1:0]                       lo, lo_next;
  logic [CW-1:0]                       hi, hi_next;

  logic                                done_next;
  logic [1:0]                          status_next;
  logic signed [skbs_pkg::LAT_W-1:0]   lat_next;
  logic signed [skbs_pkg::LON_W-1:0]   lon_next;
  logic                                ent_next;

  logic                                accept;
  logic                                full;
  logic                                order_bad;
  logic                                wr_en;
  logic                                rd_en;
  logic [CW:0]                         mid_sum;
  logic [CW-1:0]                       mid;
  logic [AW-1:0]                       rd_addr;
  logic [CW-1:0]                       mid_reg;
  logic [EW-1:0]                       rd_bits;
  skbs_pkg::entry_t                    probe;
  skbs_pkg::entry_t                    wr_entry;
  logic                                cmp_eq;
  logic                                cmp_lt;
  logic [CW-1:0]                       lo_cmp;
  logic [CW-1:0]                       hi_cmp;
  logic                                range_left;

  assign busy      = (state != skbs_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CW'(TABLE_DEPTH));
  assign order_bad = (count != '0) && (key <= last_key);
  assign wr_en     = accept && (req_type == skbs_pkg::REQ_LOAD) && !full && !order_bad;

  assign wr_entry.key  = key;
  assign wr_entry.lat  = lat_in;
  assign wr_entry.lon  = lon_in;
  assign wr_entry.flag = entrance_in;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[CW:1];
  assign rd_addr = mid[AW-1:0];
  assign rd_en   = (state == skbs_pkg::ST_ISSUE);

  assign probe      = skbs_pkg::entry_t'(rd_bits);
  assign cmp_eq     = (probe.key == target);
  assign cmp_lt     = (probe.key < target);
  assign lo_cmp     = cmp_lt ? (mid_reg + CW'(1)) : lo;
  assign hi_cmp     = cmp_lt ? hi : mid_reg;
  assign range_left = (lo_cmp < hi_cmp);

  skbs_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[AW-1:0]),
    .wr_data(wr_entry),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_bits)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      skbs_pkg::ST_IDLE: begin
        if (accept && (req_type == skbs_pkg::REQ_LOOKUP) && (count != '0)) begin
          state_next = skbs_pkg::ST_ISSUE;
        end
      end
      skbs_pkg::ST_ISSUE: begin
        state_next = skbs_pkg::ST_CMP;
      end
      skbs_pkg::ST_CMP: begin
        if (cmp_eq || !range_left) begin
          state_next = skbs_pkg::ST_IDLE;
        end else begin
          state_next = skbs_pkg::ST_ISSUE;
        end
      end
      default: begin
        state_next = skbs_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath and results
  always_comb begin
    count_next    = count;
    last_key_next = last_key;
    target_next   = target;
    lo_next       = lo;
    hi_next       = hi;
    done_next     = 1'b0;
    status_next   = skbs_pkg::STAT_NOT_FOUND;
    lat_next      = '0;
    lon_next      = '0;
    ent_next      = 1'b0;
    unique case (state)
      skbs_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (req_type)
            skbs_pkg::REQ_CLEAR: begin
              count_next  = '0;
              done_next   = 1'b1;
              status_next = skbs_pkg::STAT_OK;
            end
            skbs_pkg::REQ_LOAD: begin
              done_next = 1'b1;
              priority if (full) begin
                status_next = skbs_pkg::STAT_FULL;
              end else if (order_bad) begin
                status_next = skbs_pkg::STAT_ORDER;
              end else begin
                status_next   = skbs_pkg::STAT_OK;
                count_next    = count + CW'(1);
                last_key_next = key;
              end
            end
            skbs_pkg::REQ_LOOKUP: begin
              target_next = key;
              lo_next     = '0;
              hi_next     = count;
              if (count == '0) begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      skbs_pkg::ST_ISSUE: begin
      end
      skbs_pkg::ST_CMP: begin
        lo_next = lo_cmp;
        hi_next = hi_cmp;
        if (cmp_eq) begin
          done_next   = 1'b1;
          status_next = skbs_pkg::STAT_OK;
          lat_next    = probe.lat;
          lon_next    = probe.lon;
          ent_next    = probe.flag;
        end else if (!range_left) begin
          done_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skbs_pkg::ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
    last_key     <= last_key_next;
    target       <= target_next;
    lo           <= lo_next;
    hi           <= hi_next;
    status       <= status_next;
    lat_out      <= lat_next;
    lon_out      <= lon_next;
    entrance_out <= ent_next;
    if (rd_en) begin
      mid_reg <= mid;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_probe_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == skbs_pkg::ST_ISSUE) |-> ((lo < hi) && (hi <= count)))
    else $error("probe issued on an empty search range");

  a_cmp_after_issue: assert property (@(posedge clk) disable iff (rst)
    (state == skbs_pkg::ST_CMP) |-> ($past(state) == skbs_pkg::ST_ISSUE))
    else $error("compare without a preceding read");

  a_short_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (req_type != skbs_pkg::REQ_LOOKUP)) |=> (done && !busy))
    else $error("non-lookup transaction without a result in the next cycle");

endmodule

`default_nettype wire
